@@ rtl/hrpp_pkg.sv @@
// Shared types, constants and the digit decoder of the response packet parser.
`default_nettype none
package hrpp_pkg;

  // Restart character and the digit offsets
  localparam logic [7:0] CH_RESTART = 8'h53;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_ALPHA_OFS = CH_UPPER_A - 8'd10;
  localparam logic [7:0] CH_ZERO = 8'h30;

  // Last digit index per field and the count that marks a finished word
  localparam logic [3:0] SIZE_LAST_DIGIT = 4'd6;
  localparam logic [3:0] WORD_LAST_DIGIT = 4'd7;
  localparam logic [3:0] WORD_DONE_COUNT = 4'd8;

  // Address split
  localparam logic [31:0] DEV_MASK = 32'hFF00_0000;
  localparam logic [31:0] OFS_MASK = 32'h00FF_FFFF;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_PING      = 2'd0,
    REG_WRITE     = 2'd1,
    REG_READ      = 2'd2,
    REG_INTERRUPT = 2'd3
  } cfg_reg_t;

  // Result kinds
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_SIZE = 3'd1,
    PH_CMD  = 3'd2,
    PH_ADDR = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  typedef struct packed {
    logic [31:0] ping_code;
    logic [31:0] write_code;
    logic [31:0] read_code;
    logic [31:0] interrupt_code;
  } codes_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] command;
    logic [7:0]  device_addr;
    logic [23:0] base_offset;
    logic [27:0] word_index;
    logic [31:0] word_data;
    logic [28:0] total_words;
    logic        last;
    logic        found;
  } result_t;

  // Decode one character to a nibble; any character is taken, upper bits drop
  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [7:0] v;
    begin
      v = (c >= CH_UPPER_A) ? (c - CH_ALPHA_OFS) : (c - CH_ZERO);
      hex_digit = v[3:0];
    end
  endfunction

endpackage
`default_nettype wire

@@ rtl/hrpp_parse.sv @@
// Parse state registers and the per-character next-state and result logic.
`default_nettype none
module hrpp_parse
  import hrpp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] ch,
  input  wire codes_t     codes,
  output logic            res_valid,
  output result_t         res
);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  digit_count_r, digit_count_nxt;
  logic [27:0] size_acc_r, size_acc_nxt;
  logic [31:0] command_acc_r, command_acc_nxt;
  logic [31:0] address_acc_r, address_acc_nxt;
  logic [7:0]  device_reg_r, device_reg_nxt;
  logic [31:0] data_acc_r, data_acc_nxt;
  logic [28:0] words_left_r, words_left_nxt;
  logic [27:0] word_pos_r, word_pos_nxt;
  logic        found_flag_r, found_flag_nxt;

  logic [3:0]  d;
  logic [27:0] size_sum;
  logic [31:0] cmd_sum;
  logic [31:0] cmd_inv;
  logic [31:0] addr_sum;
  logic [31:0] data_sum;
  logic [28:0] words_dec;
  logic [28:0] total_words;

  // Shift-in sums for every field
  assign d           = hex_digit(ch);
  assign size_sum    = size_acc_r + 28'(d);
  assign cmd_sum     = command_acc_r + 32'(d);
  assign cmd_inv     = ~cmd_sum;
  assign addr_sum    = address_acc_r + 32'(d);
  assign data_sum    = data_acc_r + 32'(d);
  assign words_dec   = words_left_r - 29'd1;
  assign total_words = {1'b0, size_acc_r} + 29'd1;

  // Next state and result
  always_comb begin
    phase_nxt       = phase_r;
    digit_count_nxt = digit_count_r;
    size_acc_nxt    = size_acc_r;
    command_acc_nxt = command_acc_r;
    address_acc_nxt = address_acc_r;
    device_reg_nxt  = device_reg_r;
    data_acc_nxt    = data_acc_r;
    words_left_nxt  = words_left_r;
    word_pos_nxt    = word_pos_r;
    found_flag_nxt  = found_flag_r;
    res_valid       = 1'b0;
    res             = '0;
    res.total_words = total_words;
    res.found       = found_flag_r;

    if (ch == CH_RESTART) begin
      // Restart: clear the parse, keep the found flag
      phase_nxt       = PH_SIZE;
      digit_count_nxt = '0;
      size_acc_nxt    = '0;
      command_acc_nxt = '0;
      address_acc_nxt = '0;
      device_reg_nxt  = '0;
      data_acc_nxt    = '0;
      words_left_nxt  = '0;
      word_pos_nxt    = '0;
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
        end
        PH_SIZE: begin
          digit_count_nxt = digit_count_r + 4'd1;
          if (digit_count_r == SIZE_LAST_DIGIT) begin
            size_acc_nxt    = size_sum;
            words_left_nxt  = {1'b0, size_sum} + 29'd1;
            phase_nxt       = PH_CMD;
            digit_count_nxt = '0;
          end else begin
            size_acc_nxt = size_sum << 4;
          end
        end
        PH_CMD: begin
          digit_count_nxt = digit_count_r + 4'd1;
          if (digit_count_r == WORD_LAST_DIGIT) begin
            digit_count_nxt = '0;
            phase_nxt       = PH_ADDR;
            if (cmd_inv == codes.ping_code) begin
              command_acc_nxt = cmd_inv;
              found_flag_nxt  = 1'b1;
            end else if (cmd_inv == codes.write_code || cmd_inv == codes.read_code) begin
              command_acc_nxt = cmd_inv;
            end else if (cmd_sum == codes.interrupt_code) begin
              command_acc_nxt = cmd_sum;
            end else begin
              // Illegal command: report and drop to idle
              command_acc_nxt = cmd_sum;
              digit_count_nxt = WORD_DONE_COUNT;
              phase_nxt       = PH_IDLE;
              res_valid       = 1'b1;
              res.kind        = KIND_ERROR;
              res.command     = cmd_inv;
            end
          end else begin
            command_acc_nxt = cmd_sum << 4;
          end
        end
        PH_ADDR: begin
          digit_count_nxt = digit_count_r + 4'd1;
          if (digit_count_r == WORD_LAST_DIGIT) begin
            device_reg_nxt  = 8'((addr_sum & DEV_MASK) >> 24);
            address_acc_nxt = addr_sum & OFS_MASK;
            phase_nxt       = PH_DATA;
            digit_count_nxt = '0;
            data_acc_nxt    = '0;
          end else begin
            address_acc_nxt = addr_sum << 4;
          end
        end
        PH_DATA: begin
          digit_count_nxt = digit_count_r + 4'd1;
          if (digit_count_r == WORD_LAST_DIGIT) begin
            // Word complete: emit it
            words_left_nxt  = words_dec;
            res_valid       = 1'b1;
            res.kind        = KIND_DATA;
            res.command     = command_acc_r;
            res.device_addr = device_reg_r;
            res.base_offset = address_acc_r[23:0];
            res.word_index  = word_pos_r;
            res.word_data   = data_sum;
            res.last        = (words_dec == '0);
            if (words_dec == '0) begin
              phase_nxt    = PH_IDLE;
              data_acc_nxt = data_sum;
            end else begin
              digit_count_nxt = '0;
              data_acc_nxt    = '0;
              word_pos_nxt    = word_pos_r + 28'd1;
            end
          end else begin
            data_acc_nxt = data_sum << 4;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // State registers advance once per processed character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      digit_count_r <= '0;
      size_acc_r    <= '0;
      command_acc_r <= '0;
      address_acc_r <= '0;
      device_reg_r  <= '0;
      data_acc_r    <= '0;
      words_left_r  <= '0;
      word_pos_r    <= '0;
      found_flag_r  <= 1'b0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      digit_count_r <= digit_count_nxt;
      size_acc_r    <= size_acc_nxt;
      command_acc_r <= command_acc_nxt;
      address_acc_r <= address_acc_nxt;
      device_reg_r  <= device_reg_nxt;
      data_acc_r    <= data_acc_nxt;
      words_left_r  <= words_left_nxt;
      word_pos_r    <= word_pos_nxt;
      found_flag_r  <= found_flag_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/hex_response_packet_parser.sv @@
// Top level of the hex response packet parser: request registers and config.
//
// Takes one ASCII character per request and decodes 'S'-started response
// packets: 7 size digits, 8 command digits, 8 address digits, then size+1
// data words of 8 digits, each word giving one result (errors on an unknown
// command give one result too). One character is accepted every cycle while
// results are taken. A result is registered behind its character: the input
// register holds the character, and the parse state update and the result
// register load when the held character is processed, which can stall while
// a result waits. Write the command codes only while no packet is in flight.
`default_nettype none
module hex_response_packet_parser
  import hrpp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_ch,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [31:0]      out_command,
  output logic [7:0]       out_device_addr,
  output logic [23:0]      out_base_offset,
  output logic [27:0]      out_word_index,
  output logic [31:0]      out_word_data,
  output logic [28:0]      out_total_words,
  output logic             out_last,
  output logic             out_found,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  codes_t     codes_r;
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_ch_r;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_r;
  logic       step;
  logic       res_valid;
  result_t    res;

  // Process the held character when the result slot is free or draining
  assign step     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step;

  assign in_valid_nxt  = (in_valid_r && !step) || (in_valid && in_ready);
  assign out_valid_nxt = (step && res_valid) ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // Command code registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PING:      codes_r.ping_code      <= cfg_data;
        REG_WRITE:     codes_r.write_code     <= cfg_data;
        REG_READ:      codes_r.read_code      <= cfg_data;
        REG_INTERRUPT: codes_r.interrupt_code <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_ch_r <= in_ch;
    end
  end

  hrpp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .ch        (in_ch_r),
    .codes     (codes_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_r.kind;
  assign out_command     = out_r.command;
  assign out_device_addr = out_r.device_addr;
  assign out_base_offset = out_r.base_offset;
  assign out_word_index  = out_r.word_index;
  assign out_word_data   = out_r.word_data;
  assign out_total_words = out_r.total_words;
  assign out_last        = out_r.last;
  assign out_found       = out_r.found;

endmodule
`default_nettype wire
